[hw/rtl/oets_pkg.sv]
`default_nettype none

package oets_pkg;

    localparam int CAPACITY = 64;
    localparam int DATA_W   = 32;
    // wide enough to hold CAPACITY itself
    localparam int CNT_W    = $clog2(CAPACITY + 1);

    typedef logic signed [DATA_W-1:0] data_t;
    typedef logic [CNT_W-1:0]         count_t;

    // cell operation codes
    localparam logic [1:0] OP_HOLD  = 2'd0;
    localparam logic [1:0] OP_LOAD  = 2'd1;
    localparam logic [1:0] OP_SORT  = 2'd2;
    localparam logic [1:0] OP_SHIFT = 2'd3;

    typedef struct packed {
        logic [1:0] op;
        logic       odd;   // sort phase: lower cell of each pair has odd index
    } cell_ctrl_t;

endpackage

`default_nettype wire

[hw/rtl/odd_even_transposition_sorter.sv]
`default_nettype none

// Channel  | Direction | Handshake           | Payload
// ---------+-----------+---------------------+-----------------------------------
// input    | in        | in_valid / in_stall | value[31:0] signed, last_in
// output   | out       | out_valid/out_stall | sorted_value[31:0] signed,
//          |           |                     | last_out, overflow
//
// Load: one element per cycle, shifted into the cell row at cell 0.
// Sort: n odd-even compare-swap phases across the cell row
//   (n = elements held, at most CAPACITY).
// Emit: cell 0 is the output register; one result per cycle, row shifts down.
// Reset clears control only; cell contents are don't-care until loaded.
// in_stall is high during sort and emit; out_stall freezes the row in place.

module odd_even_transposition_sorter (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            in_valid,
    output logic                 in_stall,
    input  wire oets_pkg::data_t value,
    input  wire logic            last_in,
    output logic                 out_valid,
    input  wire logic            out_stall,
    output oets_pkg::data_t      sorted_value,
    output logic                 last_out,
    output logic                 overflow
);
    import oets_pkg::*;

    cell_ctrl_t cell_ctrl;
    count_t     count;
    data_t      cell_value [CAPACITY];

    oets_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .last_in   (last_in),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .last_out  (last_out),
        .overflow  (overflow),
        .cell_ctrl (cell_ctrl),
        .count     (count)
    );

    // Row of cells; cell i pairs with i+1 when the phase parity matches i
    // and both cells hold live elements.
    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        logic  pair_lo;
        logic  pair_hi;
        data_t left_value;
        data_t right_value;

        if (i == 0)
        begin : g_first
            assign left_value = value;         // load entry point
            assign pair_hi    = 1'b0;
        end
        else
        begin : g_mid_left
            assign left_value = cell_value[i-1];
            assign pair_hi    = (cell_ctrl.odd == ((i - 1) % 2 == 1)) &&
                                (count > count_t'(i));
        end

        if (i == CAPACITY - 1)
        begin : g_end
            assign right_value = cell_value[i];
            assign pair_lo     = 1'b0;
        end
        else
        begin : g_mid_right
            assign right_value = cell_value[i+1];
            assign pair_lo     = (cell_ctrl.odd == (i % 2 == 1)) &&
                                 (count > count_t'(i + 1));
        end

        oets_cell u_cell (
            .clk         (clk),
            .ctrl        (cell_ctrl),
            .pair_lo     (pair_lo),
            .pair_hi     (pair_hi),
            .left_value  (left_value),
            .right_value (right_value),
            .value_out   (cell_value[i])
        );
    end

    assign sorted_value = cell_value[0];

endmodule

`default_nettype wire

[hw/rtl/oets_cell.sv]
`default_nettype none

module oets_cell (
    input  wire logic               clk,
    input  wire oets_pkg::cell_ctrl_t ctrl,
    input  wire logic               pair_lo,
    input  wire logic               pair_hi,
    input  wire oets_pkg::data_t    left_value,
    input  wire oets_pkg::data_t    right_value,
    output oets_pkg::data_t         value_out
);
    import oets_pkg::*;

    data_t value_reg;
    data_t value_next;

    always_comb
    begin
        value_next = value_reg;
        unique case (ctrl.op)
            OP_HOLD:  value_next = value_reg;
            OP_LOAD:  value_next = left_value;
            OP_SHIFT: value_next = right_value;
            OP_SORT:
            begin
                // lower cell keeps the min, upper cell keeps the max
                if (pair_lo && (right_value < value_reg))
                begin
                    value_next = right_value;
                end
                else if (pair_hi && (value_reg < left_value))
                begin
                    value_next = left_value;
                end
            end
            default:  value_next = value_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
    end

    assign value_out = value_reg;

endmodule

`default_nettype wire

[hw/rtl/oets_ctrl.sv]
`default_nettype none

module oets_ctrl (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    input  wire logic                 last_in,
    output logic                      in_stall,
    output logic                      out_valid,
    input  wire logic                 out_stall,
    output logic                      last_out,
    output logic                      overflow,
    output oets_pkg::cell_ctrl_t      cell_ctrl,
    output oets_pkg::count_t          count
);
    import oets_pkg::*;

    localparam logic [1:0] ST_LOAD = 2'd0;
    localparam logic [1:0] ST_SORT = 2'd1;
    localparam logic [1:0] ST_EMIT = 2'd2;

    logic [1:0] state_reg, state_next;
    count_t     count_reg, count_next;
    count_t     phase_reg, phase_next;
    logic       dropped_reg, dropped_next;

    logic in_xfer, out_xfer, full;

    assign in_stall  = (state_reg != ST_LOAD);
    assign out_valid = (state_reg == ST_EMIT);
    assign in_xfer   = in_valid && !in_stall;
    assign out_xfer  = out_valid && !out_stall;
    assign full      = (count_reg == count_t'(CAPACITY));

    always_comb
    begin
        state_next    = state_reg;
        count_next    = count_reg;
        phase_next    = phase_reg;
        dropped_next  = dropped_reg;
        cell_ctrl.op  = OP_HOLD;
        cell_ctrl.odd = phase_reg[0];
        unique case (state_reg)
            ST_LOAD:
            begin
                if (in_xfer)
                begin
                    if (full)
                    begin
                        dropped_next = 1'b1;
                    end
                    else
                    begin
                        cell_ctrl.op = OP_LOAD;
                        count_next   = count_reg + count_t'(1);
                    end
                    if (last_in)
                    begin
                        state_next = ST_SORT;
                        phase_next = '0;
                    end
                end
            end
            ST_SORT:
            begin
                // n phases sort n elements
                cell_ctrl.op = OP_SORT;
                phase_next   = phase_reg + count_t'(1);
                if (phase_reg == count_reg - count_t'(1))
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (out_xfer)
                begin
                    cell_ctrl.op = OP_SHIFT;
                    count_next   = count_reg - count_t'(1);
                    if (count_reg == count_t'(1))
                    begin
                        state_next   = ST_LOAD;
                        dropped_next = 1'b0;
                    end
                end
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_LOAD;
            count_reg   <= '0;
            phase_reg   <= '0;
            dropped_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            phase_reg   <= phase_next;
            dropped_reg <= dropped_next;
        end
    end

    assign last_out = (count_reg == count_t'(1));
    assign overflow = dropped_reg;
    assign count    = count_reg;

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= count_t'(CAPACITY))
        else $error("element count above capacity");

    a_emit_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (count_reg != '0))
        else $error("result offered with empty store");

    a_last_ends_load: assert property (@(posedge clk) disable iff (!rst_n)
        (in_xfer && last_in) |=> (state_reg == ST_SORT))
        else $error("last transfer did not start sorting");

    a_drop_only_full: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(dropped_reg) |-> $past(full))
        else $error("element dropped while store not full");

endmodule

`default_nettype wire
